[hdl/nmea_rmc_sentence_parser_assert.svh]
// ---------------------------------------------------------------------------
// NMEA RMC parser assertion macros
// Shorthand for the clocked concurrent assertions used by the checker.
// ---------------------------------------------------------------------------
`ifndef NMEA_RMC_SENTENCE_PARSER_ASSERT_SVH
`define NMEA_RMC_SENTENCE_PARSER_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define NRMC_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger, outside reset.
`define NRMC_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

[hdl/nrmc_pkg.sv]
// ---------------------------------------------------------------------------
// NMEA RMC parser package
// Character codes, field numbers, arithmetic constants and helpers.
// ---------------------------------------------------------------------------
package nrmc_pkg;

    // Default parameter values.
    localparam int MAX_SENTENCE_LEN_DEF = 128;
    localparam int MINUTE_DECIMALS_DEF  = 4;

    // Fixed field widths.
    localparam int POS_W     = 8;
    localparam int FLD_W     = 4;
    localparam int FD_W      = 3;
    localparam int TIME_W    = 18;
    localparam int LAT_INT_W = 14;
    localparam int LON_INT_W = 15;
    localparam int LAT_OUT_W = 30;
    localparam int LON_OUT_W = 31;

    // Saturation limits.
    localparam logic [17:0] TIME_MAX    = 18'd262143;
    localparam logic [17:0] LAT_INT_MAX = 18'd16383;
    localparam logic [17:0] LON_INT_MAX = 18'd32767;
    localparam logic [31:0] LAT_E7_MAX  = 32'd900000000;
    localparam logic [31:0] LON_E7_MAX  = 32'd1800000000;

    // ASCII codes.
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_M       = 8'h4D;
    localparam logic [7:0] CH_C       = 8'h43;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_S       = 8'h53;
    localparam logic [7:0] CH_W       = 8'h57;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // Header positions, counting the dollar sign as position zero.
    localparam logic [POS_W-1:0] HDR_M_POS = 8'd4;
    localparam logic [POS_W-1:0] HDR_C_POS = 8'd5;

    // Field numbers (commas seen so far).
    localparam logic [FLD_W-1:0] FLD_TIME   = 4'd1;
    localparam logic [FLD_W-1:0] FLD_STATUS = 4'd2;
    localparam logic [FLD_W-1:0] FLD_LAT    = 4'd3;
    localparam logic [FLD_W-1:0] FLD_NS     = 4'd4;
    localparam logic [FLD_W-1:0] FLD_LON    = 4'd5;
    localparam logic [FLD_W-1:0] FLD_EW     = 4'd6;
    localparam logic [FLD_W-1:0] FLD_DONE   = 4'd7;
    localparam logic [FLD_W-1:0] FLD_SAT    = 4'd15;

    // Flag bit positions.
    localparam int FLAG_FIX  = 0;
    localparam int FLAG_SOUTH = 1;
    localparam int FLAG_WEST = 2;

    // Division by 100 of a value below 2^15: (x * 5243) >> 19 is exact.
    localparam logic [12:0] DIV100_RECIP = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    // Division by 60 of a value below 10^9: (x * 1145324613) >> 36 is exact.
    localparam logic [30:0] DIV60_RECIP = 31'd1145324613;
    localparam int          DIV60_SHIFT = 36;
    localparam int          NUM_W       = 30;
    localparam int          Q60_W       = 24;

    localparam logic [23:0] E7_SCALE = 24'd10000000;
    localparam int          E7_DIGITS = 7;

    // Pipeline stage enables of the degree converter.
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } conv_en_t;

    // Ten to the power n, n at most eight.
    function automatic logic [31:0] pow10(input int unsigned n);
        logic [31:0] r;
        r = 32'd1;
        for (int k = 0; k < 8; k++)
        begin
            if (k < n)
            begin
                r = 32'(r * 32'd10);
            end
        end
        return r;
    endfunction

    // Append one decimal digit to an accumulator, saturating at lim.
    function automatic logic [17:0] sat_dec(input logic [17:0] acc, input logic [3:0] d,
                                            input logic [17:0] lim);
        logic [21:0] v;
        v = 22'(acc) * 22'd10 + 22'(d);
        return (v > 22'(lim)) ? lim : v[17:0];
    endfunction

endpackage

[hdl/nmea_rmc_sentence_parser.sv]
// ---------------------------------------------------------------------------
// NMEA RMC sentence parser
// Parses a byte stream of NMEA sentences and reports time and position.
// ---------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall, rx_byte) takes one character
// per transfer. A dollar sign starts a sentence; only RMC sentences are
// decoded. The output channel (out_valid, out_stall and the result fields)
// gives one transfer per complete sentence, on its newline.
// Throughput: one character per cycle while in_stall is low. The parser
// updates its field state in the cycle a character is taken; no
// character waits for another. The capture register loads on the
// newline's transfer, then four converter stages and the output register
// follow. The converter pipeline collapses bubbles, so a stalled output
// only stops the input once every stage behind it holds a result, which
// needs several sentences to pile up.
// Reset: rst_n clears the parser state and empties the pipeline; bytes
// before the first dollar sign are ignored.
// ---------------------------------------------------------------------------
module nmea_rmc_sentence_parser
    import nrmc_pkg::*;
#(
    parameter int MAX_SENTENCE_LEN = MAX_SENTENCE_LEN_DEF,
    parameter int MINUTE_DECIMALS  = MINUTE_DECIMALS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            rx_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [TIME_W-1:0]     utc_hhmmss,
    output logic                  fix_valid,
    output logic [LAT_OUT_W-1:0]  latitude_e7,
    output logic                  south,
    output logic [LON_OUT_W-1:0]  longitude_e7,
    output logic                  west
);

    localparam int FRAC_W = $clog2(pow10(MINUTE_DECIMALS));

    typedef struct packed {
        logic [TIME_W-1:0] utc;
        logic [2:0]        flags;
    } side_t;

    // Parser state.
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [FLD_W-1:0]     fld_reg, fld_next;
    logic                 active_reg, active_next;
    logic                 header_reg, header_next;
    logic                 in_frac_reg, in_frac_next;
    logic [FD_W-1:0]      fd_reg, fd_next;
    logic [TIME_W-1:0]    time_reg, time_next;
    logic [LAT_INT_W-1:0] lat_int_reg, lat_int_next;
    logic [FRAC_W-1:0]    lat_frac_reg, lat_frac_next;
    logic [LON_INT_W-1:0] lon_int_reg, lon_int_next;
    logic [FRAC_W-1:0]    lon_frac_reg, lon_frac_next;
    logic [2:0]           flags_reg, flags_next;

    // Capture stage and pipeline control.
    logic [LAT_INT_W-1:0] cap_lat_int_reg;
    logic [FRAC_W-1:0]    cap_lat_frac_reg;
    logic [LON_INT_W-1:0] cap_lon_int_reg;
    logic [FRAC_W-1:0]    cap_lon_frac_reg;
    side_t                side_reg [1:5];
    logic [5:1]           vld_reg, vld_next;
    logic [5:1]           rdy;
    logic                 out_ready;
    logic                 out_valid_reg;
    conv_en_t             conv_en;

    // Output registers.
    logic [TIME_W-1:0]    utc_reg;
    logic                 fix_reg;
    logic [LAT_OUT_W-1:0] lat_e7_reg;
    logic                 south_reg;
    logic [LON_OUT_W-1:0] lon_e7_reg;
    logic                 west_reg;
    logic [LAT_OUT_W-1:0] lat_e7;
    logic [LON_OUT_W-1:0] lon_e7;

    // Decode of the current character.
    logic                 accept;
    logic                 emit;
    logic                 is_digit;
    logic [3:0]           digit;
    logic [7:0]           digit_full;
    logic [FD_W-1:0]      pad_exp;
    logic [31:0]          lat_pad;
    logic [31:0]          lon_pad;
    logic [FRAC_W+3:0]    lat_frac_dig;
    logic [FRAC_W+3:0]    lon_frac_dig;

    assign digit_full = rx_byte - CH_ZERO;
    assign digit      = digit_full[3:0];
    assign is_digit   = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);

    // Pad missing minute decimals with zeros when the field closes.
    assign pad_exp = (fd_reg < FD_W'(MINUTE_DECIMALS)) ? (FD_W'(MINUTE_DECIMALS) - fd_reg)
                                                      : '0;
    assign lat_pad = 32'(lat_frac_reg) * pow10(32'(pad_exp));
    assign lon_pad = 32'(lon_frac_reg) * pow10(32'(pad_exp));

    assign lat_frac_dig = (FRAC_W+4)'(lat_frac_reg) * (FRAC_W+4)'(10) + (FRAC_W+4)'(digit);
    assign lon_frac_dig = (FRAC_W+4)'(lon_frac_reg) * (FRAC_W+4)'(10) + (FRAC_W+4)'(digit);

    // Ready chain of the result pipeline; an empty stage always takes data.
    always_comb
    begin
        out_ready = !out_valid_reg || !out_stall;
        rdy[5]    = !vld_reg[5] || out_ready;
        for (int i = 4; i >= 1; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign in_stall = vld_reg[1] && !rdy[2];
    assign accept   = in_valid && !in_stall;

    assign conv_en.s2 = rdy[2];
    assign conv_en.s3 = rdy[3];
    assign conv_en.s4 = rdy[4];
    assign conv_en.s5 = rdy[5];

    // Per-character sentence parser.
    always_comb
    begin
        pos_next      = pos_reg;
        fld_next      = fld_reg;
        active_next   = active_reg;
        header_next   = header_reg;
        in_frac_next  = in_frac_reg;
        fd_next       = fd_reg;
        time_next     = time_reg;
        lat_int_next  = lat_int_reg;
        lat_frac_next = lat_frac_reg;
        lon_int_next  = lon_int_reg;
        lon_frac_next = lon_frac_reg;
        flags_next    = flags_reg;
        emit          = 1'b0;

        if (accept)
        begin
            if (rx_byte == CH_DOLLAR)
            begin
                pos_next      = POS_W'(1);
                fld_next      = '0;
                active_next   = 1'b1;
                header_next   = 1'b0;
                in_frac_next  = 1'b0;
                fd_next       = '0;
                time_next     = '0;
                lat_int_next  = '0;
                lat_frac_next = '0;
                lon_int_next  = '0;
                lon_frac_next = '0;
                flags_next    = '0;
            end
            else if (!active_reg)
            begin
                active_next = 1'b0;
            end
            else if (pos_reg >= POS_W'(MAX_SENTENCE_LEN))
            begin
                active_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                if (!header_reg)
                begin
                    // Talker and sentence type; only the M and C of RMC are checked.
                    if ((rx_byte == CH_NEWLINE) ||
                        ((pos_reg == HDR_M_POS) && (rx_byte != CH_M)) ||
                        ((pos_reg == HDR_C_POS) && (rx_byte != CH_C)))
                    begin
                        active_next = 1'b0;
                    end
                    else if (pos_reg == HDR_C_POS)
                    begin
                        header_next = 1'b1;
                    end
                end
                else if (rx_byte == CH_NEWLINE)
                begin
                    active_next = 1'b0;
                    emit        = (fld_reg >= FLD_DONE);
                end
                else if (rx_byte == CH_COMMA)
                begin
                    if (fld_reg == FLD_LAT)
                    begin
                        lat_frac_next = lat_pad[FRAC_W-1:0];
                    end
                    else if (fld_reg == FLD_LON)
                    begin
                        lon_frac_next = lon_pad[FRAC_W-1:0];
                    end
                    if (fld_reg != FLD_SAT)
                    begin
                        fld_next = fld_reg + FLD_W'(1);
                    end
                    in_frac_next = 1'b0;
                    fd_next      = '0;
                end
                else
                begin
                    unique case (fld_reg)
                        FLD_TIME:
                        begin
                            if (rx_byte == CH_DOT)
                            begin
                                in_frac_next = 1'b1;
                            end
                            else if (is_digit && !in_frac_reg)
                            begin
                                time_next = sat_dec(time_reg, digit, TIME_MAX);
                            end
                        end
                        FLD_STATUS, FLD_NS, FLD_EW:
                        begin
                            // Only the first character of a flag field counts.
                            if (fd_reg == '0)
                            begin
                                if ((fld_reg == FLD_STATUS) && (rx_byte == CH_A))
                                begin
                                    flags_next[FLAG_FIX] = 1'b1;
                                end
                                if ((fld_reg == FLD_NS) && (rx_byte == CH_S))
                                begin
                                    flags_next[FLAG_SOUTH] = 1'b1;
                                end
                                if ((fld_reg == FLD_EW) && (rx_byte == CH_W))
                                begin
                                    flags_next[FLAG_WEST] = 1'b1;
                                end
                                fd_next = FD_W'(1);
                            end
                        end
                        FLD_LAT, FLD_LON:
                        begin
                            if (rx_byte == CH_DOT)
                            begin
                                in_frac_next = 1'b1;
                            end
                            else if (is_digit)
                            begin
                                if (in_frac_reg)
                                begin
                                    if (fd_reg < FD_W'(MINUTE_DECIMALS))
                                    begin
                                        if (fld_reg == FLD_LAT)
                                        begin
                                            lat_frac_next = lat_frac_dig[FRAC_W-1:0];
                                        end
                                        else
                                        begin
                                            lon_frac_next = lon_frac_dig[FRAC_W-1:0];
                                        end
                                        fd_next = fd_reg + FD_W'(1);
                                    end
                                end
                                else if (fld_reg == FLD_LAT)
                                begin
                                    lat_int_next = LAT_INT_W'(sat_dec(18'(lat_int_reg), digit,
                                                                      LAT_INT_MAX));
                                end
                                else
                                begin
                                    lon_int_next = LON_INT_W'(sat_dec(18'(lon_int_reg), digit,
                                                                      LON_INT_MAX));
                                end
                            end
                        end
                        default:
                        begin
                            in_frac_next = in_frac_reg;
                        end
                    endcase
                end
            end
        end
    end

    // Valid bits of the capture stage and the converter stages.
    always_comb
    begin
        vld_next = vld_reg;
        if (emit)
        begin
            vld_next[1] = 1'b1;
        end
        else if (rdy[2])
        begin
            vld_next[1] = 1'b0;
        end
        for (int i = 2; i <= 5; i++)
        begin
            if (rdy[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    // Control and parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            fld_reg       <= '0;
            active_reg    <= 1'b0;
            header_reg    <= 1'b0;
            in_frac_reg   <= 1'b0;
            fd_reg        <= '0;
            time_reg      <= '0;
            lat_int_reg   <= '0;
            lat_frac_reg  <= '0;
            lon_int_reg   <= '0;
            lon_frac_reg  <= '0;
            flags_reg     <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            fld_reg      <= fld_next;
            active_reg   <= active_next;
            header_reg   <= header_next;
            in_frac_reg  <= in_frac_next;
            fd_reg       <= fd_next;
            time_reg     <= time_next;
            lat_int_reg  <= lat_int_next;
            lat_frac_reg <= lat_frac_next;
            lon_int_reg  <= lon_int_next;
            lon_frac_reg <= lon_frac_next;
            flags_reg    <= flags_next;
            vld_reg      <= vld_next;
            if (out_ready)
            begin
                out_valid_reg <= vld_reg[5];
            end
        end
    end

    // Capture of a finished sentence and the delay line for time and flags.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            cap_lat_int_reg    <= lat_int_reg;
            cap_lat_frac_reg   <= lat_frac_reg;
            cap_lon_int_reg    <= lon_int_reg;
            cap_lon_frac_reg   <= lon_frac_reg;
            side_reg[1].utc    <= time_reg;
            side_reg[1].flags  <= flags_reg;
        end
        for (int i = 2; i <= 5; i++)
        begin
            if (rdy[i])
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Latitude and longitude converters.
    nrmc_deg_conv #(
        .INT_W           (LAT_INT_W),
        .OUT_W           (LAT_OUT_W),
        .MINUTE_DECIMALS (MINUTE_DECIMALS),
        .E7_MAX          (LAT_E7_MAX)
    ) u_lat_conv (
        .clk   (clk),
        .en    (conv_en),
        .ipart (cap_lat_int_reg),
        .frac  (cap_lat_frac_reg),
        .e7    (lat_e7)
    );

    nrmc_deg_conv #(
        .INT_W           (LON_INT_W),
        .OUT_W           (LON_OUT_W),
        .MINUTE_DECIMALS (MINUTE_DECIMALS),
        .E7_MAX          (LON_E7_MAX)
    ) u_lon_conv (
        .clk   (clk),
        .en    (conv_en),
        .ipart (cap_lon_int_reg),
        .frac  (cap_lon_frac_reg),
        .e7    (lon_e7)
    );

    // Output register; holds while the receiver stalls.
    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            utc_reg    <= side_reg[5].utc;
            fix_reg    <= side_reg[5].flags[FLAG_FIX];
            south_reg  <= side_reg[5].flags[FLAG_SOUTH];
            west_reg   <= side_reg[5].flags[FLAG_WEST];
            lat_e7_reg <= lat_e7;
            lon_e7_reg <= lon_e7;
        end
    end

    assign out_valid    = out_valid_reg;
    assign utc_hhmmss   = utc_reg;
    assign fix_valid    = fix_reg;
    assign latitude_e7  = lat_e7_reg;
    assign south        = south_reg;
    assign longitude_e7 = lon_e7_reg;
    assign west         = west_reg;

endmodule

[hdl/nrmc_deg_conv.sv]
// ---------------------------------------------------------------------------
// NMEA RMC degree converter
// Turns ddmm / dddmm plus minute decimals into 1e-7 degree, in four stages.
// ---------------------------------------------------------------------------
module nrmc_deg_conv
    import nrmc_pkg::*;
#(
    parameter int          INT_W           = LAT_INT_W,
    parameter int          OUT_W           = LAT_OUT_W,
    parameter int          MINUTE_DECIMALS = MINUTE_DECIMALS_DEF,
    parameter logic [31:0] E7_MAX          = LAT_E7_MAX
)
(
    input  logic                                            clk,
    input  conv_en_t                                        en,
    input  logic [INT_W-1:0]                                ipart,
    input  logic [$clog2(pow10(MINUTE_DECIMALS))-1:0]       frac,
    output logic [OUT_W-1:0]                                e7
);

    localparam int          FRAC_W    = $clog2(pow10(MINUTE_DECIMALS));
    localparam int          M_W       = $clog2(100 * pow10(MINUTE_DECIMALS));
    localparam int          DEG_W     = INT_W - 6;
    localparam int          DEGE7_W   = DEG_W + 24;
    localparam logic [31:0] MIN_SCALE = pow10(MINUTE_DECIMALS);
    localparam logic [31:0] NUM_SCALE = pow10(E7_DIGITS - MINUTE_DECIMALS);

    logic [INT_W+12:0]   prod100;
    logic [INT_W-1:0]    s2_int_reg;
    logic [DEG_W-1:0]    s2_deg_reg;
    logic [FRAC_W-1:0]   s2_frac_reg;
    logic [INT_W-1:0]    rem100;
    logic [31:0]         m_full;
    logic [DEG_W-1:0]    s3_deg_reg;
    logic [M_W-1:0]      s3_m_reg;
    logic [31:0]         num_full;
    logic [NUM_W-1:0]    s4_num_reg;
    logic [DEGE7_W-1:0]  s4_dege7_reg;
    logic [NUM_W+30:0]   prod60;
    logic [Q60_W-1:0]    s5_q60_reg;
    logic [DEGE7_W-1:0]  s5_dege7_reg;
    logic [DEGE7_W:0]    sum;

    // Stage 2: whole degrees by reciprocal multiplication.
    assign prod100 = (INT_W+13)'(ipart) * (INT_W+13)'(DIV100_RECIP);

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            s2_int_reg  <= ipart;
            s2_deg_reg  <= prod100[DIV100_SHIFT +: DEG_W];
            s2_frac_reg <= frac;
        end
    end

    // Stage 3: total minutes scaled by the decimal count.
    assign rem100 = s2_int_reg - INT_W'(s2_deg_reg) * INT_W'(7'd100);
    assign m_full = 32'(rem100[6:0]) * MIN_SCALE + 32'(s2_frac_reg);

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            s3_deg_reg <= s2_deg_reg;
            s3_m_reg   <= m_full[M_W-1:0];
        end
    end

    // Stage 4: minutes to 1e-7 units before the divide by 60, and degrees times 1e7.
    assign num_full = 32'(s3_m_reg) * NUM_SCALE;

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            s4_num_reg   <= num_full[NUM_W-1:0];
            s4_dege7_reg <= DEGE7_W'(s3_deg_reg) * DEGE7_W'(E7_SCALE);
        end
    end

    // Stage 5: divide by 60 through the reciprocal.
    assign prod60 = (NUM_W+31)'(s4_num_reg) * (NUM_W+31)'(DIV60_RECIP);

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            s5_q60_reg   <= prod60[DIV60_SHIFT +: Q60_W];
            s5_dege7_reg <= s4_dege7_reg;
        end
    end

    // Final sum and saturation, registered by the caller.
    assign sum = (DEGE7_W+1)'(s5_dege7_reg) + (DEGE7_W+1)'(s5_q60_reg);
    assign e7  = (sum > (DEGE7_W+1)'(E7_MAX)) ? OUT_W'(E7_MAX) : OUT_W'(sum);

endmodule

[hdl/nrmc_checker.sv]
// ---------------------------------------------------------------------------
// NMEA RMC parser checker
// Port-level assertions on the parser, attached by a bind statement.
// ---------------------------------------------------------------------------
`include "nmea_rmc_sentence_parser_assert.svh"

module nrmc_checker
    import nrmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [7:0]            rx_byte,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [TIME_W-1:0]     utc_hhmmss,
    input  logic                  fix_valid,
    input  logic [LAT_OUT_W-1:0]  latitude_e7,
    input  logic                  south,
    input  logic [LON_OUT_W-1:0]  longitude_e7,
    input  logic                  west
);

    // A stalled result keeps its value until it is transferred.
    `NRMC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(latitude_e7) && $stable(longitude_e7) && $stable(utc_hhmmss), "stalled result changed")

    // Converted positions never exceed the saturation limits.
    `NRMC_ASSERT_ALWAYS(a_lat_range, clk, rst_n, !out_valid || (32'(latitude_e7) <= LAT_E7_MAX), "latitude out of range")
    `NRMC_ASSERT_ALWAYS(a_lon_range, clk, rst_n, !out_valid || (32'(longitude_e7) <= LON_E7_MAX), "longitude out of range")

    // The input is held back only when a result waits on a stalled output.
    `NRMC_ASSERT_ALWAYS(a_stall_cause, clk, rst_n, !in_stall || (out_valid && out_stall), "input stalled without output backpressure")

endmodule

bind nmea_rmc_sentence_parser nrmc_checker u_nrmc_checker (.*);

[tb/sv/nmea_rmc_sentence_parser_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// NMEA RMC sentence parser testbench
// Streams NMEA text into the parser one character per transfer and checks
// every reported fix against a cycle-free parser model kept in the bench.
// A directed set of sentences covers zero and extreme coordinates,
// saturation, malformed headers, restarts and length limits. It is followed
// by randomly built RMC sentences mixed with broken sentences and raw noise.
// Both channels idle at random, the result side holds off for a long
// stretch so the pipeline fills, and the sender pauses to let the
// parser drain.
// ---------------------------------------------------------------------------
module nmea_rmc_sentence_parser_tb;
    import nrmc_pkg::*;

    localparam int unsigned LIMIT_CYCLES     = 200000;
    localparam int unsigned LONG_HOLD_CYCLES = 1500;
    localparam int unsigned DRAIN_LIMIT      = 4000;
    localparam int unsigned TAIL_CYCLES      = 40;
    localparam int unsigned IDLE_PERCENT     = 21;
    localparam int unsigned MIN_RANDOM_CHARS = 500;
    localparam int unsigned MIN_GOOD_LINES   = 8;
    localparam int unsigned RANDOM_ITERS     = 13;

    // Entries of the stimulus queue: characters and control points.
    typedef enum logic [1:0] {
        STIM_CHAR,
        STIM_DRAIN,
        STIM_HOLD_OUT,
        STIM_CALM_TOGGLE
    } stim_kind_t;

    typedef struct {
        stim_kind_t kind;
        logic [7:0] ch;
    } stim_entry_t;

    // One reported fix.
    typedef struct {
        logic [TIME_W-1:0]    utc;
        logic                 fix;
        logic [LAT_OUT_W-1:0] lat;
        logic                 south_hemi;
        logic [LON_OUT_W-1:0] lon;
        logic                 west_hemi;
    } fix_report_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [7:0]           rx_byte   = 8'd0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [TIME_W-1:0]    utc_hhmmss;
    logic                 fix_valid;
    logic [LAT_OUT_W-1:0] latitude_e7;
    logic                 south;
    logic [LON_OUT_W-1:0] longitude_e7;
    logic                 west;

    // Control between the sender and the receiver.
    logic        hold_kick = 1'b0;
    logic        calm      = 1'b0;
    logic [11:0] hold_left = '0;
    bit          drain_wait;

    stim_entry_t stim_q[$];
    fix_report_t pending_fixes[$];
    int unsigned queued_chars;
    int unsigned error_count;
    int unsigned cycle_count;

    // Parser model state.
    logic [POS_W-1:0]     m_pos;
    logic [FLD_W-1:0]     m_field;
    logic                 m_active;
    logic                 m_hdr_ok;
    logic                 m_in_frac;
    logic [FD_W-1:0]      m_ndig;
    logic [TIME_W-1:0]    m_time;
    logic [LAT_INT_W-1:0] m_lat_int;
    logic [13:0]          m_lat_frac;
    logic [LON_INT_W-1:0] m_lon_int;
    logic [13:0]          m_lon_frac;
    logic [2:0]           m_flags;

    nmea_rmc_sentence_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .utc_hhmmss   (utc_hhmmss),
        .fix_valid    (fix_valid),
        .latitude_e7  (latitude_e7),
        .south        (south),
        .longitude_e7 (longitude_e7),
        .west         (west)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Model: clear all sentence state.
    task automatic clear_parser();
        m_pos      = '0;
        m_field    = '0;
        m_active   = 1'b0;
        m_hdr_ok   = 1'b0;
        m_in_frac  = 1'b0;
        m_ndig     = '0;
        m_time     = '0;
        m_lat_int  = '0;
        m_lat_frac = '0;
        m_lon_int  = '0;
        m_lon_frac = '0;
        m_flags    = '0;
    endtask

    // Append a decimal digit, saturating at the accumulator limit.
    function automatic int unsigned append_digit(int unsigned acc, int unsigned d,
                                                 int unsigned lim);
        int unsigned v;
        v = acc * 10 + d;
        return (v > lim) ? lim : v;
    endfunction

    // Scale a minute fraction up to the full number of decimals.
    function automatic logic [13:0] pad_minutes(logic [13:0] frac, logic [FD_W-1:0] ndig);
        for (int k = ndig; k < MINUTE_DECIMALS_DEF; k++)
        begin
            frac = 14'(frac * 10);
        end
        return frac;
    endfunction

    // Convert ddmm plus minute fraction to 1e-7 degree units, saturating.
    function automatic longint unsigned minutes_to_e7(longint unsigned whole,
                                                      longint unsigned frac,
                                                      longint unsigned cap);
        longint unsigned scale;
        longint unsigned mins;
        longint unsigned v;
        scale = 1;
        for (int k = 0; k < MINUTE_DECIMALS_DEF; k++)
        begin
            scale = scale * 10;
        end
        mins = (whole % 100) * scale + frac;
        v = (whole / 100) * 64'd10000000 + (mins * 64'd10000000) / (60 * scale);
        return (v > cap) ? cap : v;
    endfunction

    // Model: take one character, queue a fix when a complete sentence ends.
    task automatic parse_char(input logic [7:0] ch);
        logic             is_digit;
        int unsigned      dval;
        logic [POS_W-1:0] at;
        fix_report_t      rep;
        is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        dval = is_digit ? int'(ch - CH_ZERO) : 0;
        if (ch == CH_DOLLAR)
        begin
            clear_parser();
            m_active = 1'b1;
            m_pos    = 8'd1;
            return;
        end
        if (!m_active)
        begin
            return;
        end
        if (m_pos >= MAX_SENTENCE_LEN_DEF)
        begin
            m_active = 1'b0;
            return;
        end
        at = m_pos;
        m_pos = m_pos + 1'b1;

        // Header: only positions four and five are checked.
        if (!m_hdr_ok)
        begin
            if (ch == CH_NEWLINE || (at == HDR_M_POS && ch != CH_M) ||
                (at == HDR_C_POS && ch != CH_C))
            begin
                m_active = 1'b0;
            end
            else if (at == HDR_C_POS)
            begin
                m_hdr_ok = 1'b1;
            end
            return;
        end

        if (ch == CH_NEWLINE)
        begin
            m_active = 1'b0;
            if (m_field >= FLD_DONE)
            begin
                rep.utc        = m_time;
                rep.fix        = m_flags[FLAG_FIX];
                rep.lat        = LAT_OUT_W'(minutes_to_e7(m_lat_int, m_lat_frac,
                                                          LAT_E7_MAX));
                rep.south_hemi = m_flags[FLAG_SOUTH];
                rep.lon        = LON_OUT_W'(minutes_to_e7(m_lon_int, m_lon_frac,
                                                          LON_E7_MAX));
                rep.west_hemi  = m_flags[FLAG_WEST];
                pending_fixes.push_back(rep);
            end
            return;
        end

        if (ch == CH_COMMA)
        begin
            if (m_field == FLD_LAT)
            begin
                m_lat_frac = pad_minutes(m_lat_frac, m_ndig);
            end
            else if (m_field == FLD_LON)
            begin
                m_lon_frac = pad_minutes(m_lon_frac, m_ndig);
            end
            if (m_field != FLD_SAT)
            begin
                m_field = m_field + 1'b1;
            end
            m_in_frac = 1'b0;
            m_ndig    = '0;
            return;
        end

        case (m_field)
            FLD_TIME:
            begin
                if (ch == CH_DOT)
                begin
                    m_in_frac = 1'b1;
                end
                else if (is_digit && !m_in_frac)
                begin
                    m_time = TIME_W'(append_digit(m_time, dval, TIME_MAX));
                end
            end
            FLD_STATUS, FLD_NS, FLD_EW:
            begin
                // Only the first character of a flag field counts.
                if (m_ndig == 0)
                begin
                    if (m_field == FLD_STATUS && ch == CH_A)
                    begin
                        m_flags[FLAG_FIX] = 1'b1;
                    end
                    if (m_field == FLD_NS && ch == CH_S)
                    begin
                        m_flags[FLAG_SOUTH] = 1'b1;
                    end
                    if (m_field == FLD_EW && ch == CH_W)
                    begin
                        m_flags[FLAG_WEST] = 1'b1;
                    end
                    m_ndig = 3'd1;
                end
            end
            FLD_LAT, FLD_LON:
            begin
                if (ch == CH_DOT)
                begin
                    m_in_frac = 1'b1;
                end
                else if (is_digit && m_in_frac)
                begin
                    if (m_ndig < MINUTE_DECIMALS_DEF)
                    begin
                        if (m_field == FLD_LAT)
                        begin
                            m_lat_frac = 14'(m_lat_frac * 10 + dval);
                        end
                        else
                        begin
                            m_lon_frac = 14'(m_lon_frac * 10 + dval);
                        end
                        m_ndig = m_ndig + 1'b1;
                    end
                end
                else if (is_digit && m_field == FLD_LAT)
                begin
                    m_lat_int = LAT_INT_W'(append_digit(m_lat_int, dval, LAT_INT_MAX));
                end
                else if (is_digit)
                begin
                    m_lon_int = LON_INT_W'(append_digit(m_lon_int, dval, LON_INT_MAX));
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Stimulus helpers.
    function automatic void push_char(logic [7:0] b);
        stim_q.push_back('{STIM_CHAR, b});
        queued_chars++;
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_char(s[i]);
        end
    endfunction

    function automatic void push_marker(stim_kind_t kind);
        stim_q.push_back('{kind, 8'd0});
    endfunction

    function automatic string digit_run(int unsigned n);
        string s;
        s = "";
        for (int unsigned i = 0; i < n; i++)
        begin
            s = {s, $sformatf("%0d", $urandom_range(9))};
        end
        return s;
    endfunction

    function automatic string line_end();
        return $urandom_range(1) ? "\n" : $sformatf("%c\n", 8'd13);
    endfunction

    // Pad a sentence body with filler so its newline lands at a given index.
    function automatic string padded_line(string body, int unsigned nl_at);
        string s;
        s = body;
        while (s.len() < nl_at)
        begin
            s = {s, "x"};
        end
        return {s, "\n"};
    endfunction

    function automatic string flag_text(logic [7:0] want, logic [7:0] other);
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
        begin
            return "";
        end
        if (r == 1)
        begin
            return $sformatf("%c", 8'($urandom_range(8'h41, 8'h5A)));
        end
        return $sformatf("%c", (r <= 5) ? want : other);
    endfunction

    // Coordinate field in ddmm.mmmm or dddmm.mmmm form, sometimes odd lengths.
    function automatic string coord_text(bit three_digit_deg, int unsigned deg_max);
        string s;
        if ($urandom_range(4) == 0)
        begin
            s = digit_run($urandom_range(0, 7));
        end
        else if (three_digit_deg)
        begin
            s = $sformatf("%03d%02d", $urandom_range(deg_max), $urandom_range(59));
        end
        else
        begin
            s = $sformatf("%02d%02d", $urandom_range(deg_max), $urandom_range(59));
        end
        if ($urandom_range(9) != 0)
        begin
            s = {s, ".", digit_run($urandom_range(0, 6))};
        end
        return s;
    endfunction

    // A well-formed RMC sentence with random content.
    function automatic string make_rmc();
        string talker;
        string utc;
        string tail;
        case ($urandom_range(3))
            0: talker = "GP";
            1: talker = "GN";
            2: talker = "GL";
            default: talker = "BD";
        endcase
        if ($urandom_range(9) == 0)
        begin
            utc = digit_run($urandom_range(0, 9));
        end
        else
        begin
            utc = $sformatf("%02d%02d%02d", $urandom_range(23), $urandom_range(59),
                            $urandom_range(59));
            if ($urandom_range(1))
            begin
                utc = {utc, ".", digit_run($urandom_range(1, 3))};
            end
        end
        case ($urandom_range(2))
            0: tail = "";
            1: tail = "0.5,54.7,191194,020.3,E*68";
            default: tail = ",,A*6C";
        endcase
        return {"$", talker, "RMC,", utc, ",", flag_text(CH_A, 8'h56), ",",
                coord_text(1'b0, 90), ",", flag_text(CH_S, 8'h4E), ",",
                coord_text(1'b1, 180), ",", flag_text(CH_W, 8'h45), ",",
                tail, line_end()};
    endfunction

    // Sender: offers queued characters, idles at random, obeys control points.
    always @(posedge clk or negedge rst_n)
    begin : drive_blk
        stim_entry_t entry;
        logic        valid_next;
        logic        kick_next;
        logic        calm_next;
        logic [7:0]  byte_next;
        if (!rst_n)
        begin
            clear_parser();
            drain_wait = 1'b0;
            in_valid  <= 1'b0;
            rx_byte   <= 8'd0;
            hold_kick <= 1'b0;
            calm      <= 1'b0;
        end
        else
        begin
            kick_next = 1'b0;
            calm_next = calm;
            byte_next = rx_byte;
            if (in_valid && !in_stall)
            begin
                parse_char(rx_byte);
            end
            if (!in_valid || !in_stall)
            begin
                valid_next = 1'b0;
                if (drain_wait && pending_fixes.size() == 0)
                begin
                    drain_wait = 1'b0;
                end
                if (!drain_wait && stim_q.size() != 0 &&
                    (calm || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    entry = stim_q.pop_front();
                    case (entry.kind)
                        STIM_CHAR:
                        begin
                            valid_next = 1'b1;
                            byte_next  = entry.ch;
                        end
                        STIM_DRAIN:       drain_wait = 1'b1;
                        STIM_HOLD_OUT:    kick_next = 1'b1;
                        STIM_CALM_TOGGLE: calm_next = !calm;
                        default:
                        begin
                        end
                    endcase
                end
                in_valid <= valid_next;
                rx_byte  <= byte_next;
            end
            hold_kick <= kick_next;
            calm      <= calm_next;
        end
    end

    // Receiver stall: random, or a long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= '0;
        end
        else if (hold_kick)
        begin
            out_stall <= 1'b1;
            hold_left <= 12'(LONG_HOLD_CYCLES);
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1'b1;
        end
        else
        begin
            out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Result checker: each transfer is compared with the oldest expected fix.
    always @(posedge clk)
    begin : check_blk
        fix_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_fixes.size() == 0)
            begin
                $error("Unexpected fix reported: utc %0d lat %0d lon %0d",
                       utc_hhmmss, latitude_e7, longitude_e7);
                error_count++;
            end
            else
            begin
                want = pending_fixes.pop_front();
                if (utc_hhmmss !== want.utc)
                begin
                    $error("utc_hhmmss: expected %0d, got %0d", want.utc, utc_hhmmss);
                    error_count++;
                end
                if (fix_valid !== want.fix)
                begin
                    $error("fix_valid: expected %0d, got %0d", want.fix, fix_valid);
                    error_count++;
                end
                if (latitude_e7 !== want.lat)
                begin
                    $error("latitude_e7: expected %0d, got %0d", want.lat, latitude_e7);
                    error_count++;
                end
                if (south !== want.south_hemi)
                begin
                    $error("south: expected %0d, got %0d", want.south_hemi, south);
                    error_count++;
                end
                if (longitude_e7 !== want.lon)
                begin
                    $error("longitude_e7: expected %0d, got %0d", want.lon, longitude_e7);
                    error_count++;
                end
                if (west !== want.west_hemi)
                begin
                    $error("west: expected %0d, got %0d", want.west_hemi, west);
                    error_count++;
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $error("Run limit of %0d cycles reached", LIMIT_CYCLES);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus plan, reset and end of run.
    initial
    begin
        string       s;
        int unsigned iter;
        int unsigned good_lines;
        int unsigned k;
        int unsigned wait_cycles;

        // Directed sentences: zeros and in-range extremes.
        push_text("$GPRMC,000000.00,A,0000.0000,N,00000.0000,E,0.0,0.0,010100,,,A*6C\n");
        push_text("$GNRMC,235959.99,A,9000.0000,S,18000.0000,W,,\n");
        // Out-of-range positions saturate.
        push_text("$GPRMC,123519,V,9959.9999,N,99959.9999,E,,\n");
        // Accumulator overflow in time, latitude and longitude.
        push_text("$GPRMC,99999999999,A,999999999.9,S,9999999999.9,W,,\n");
        // Extra and missing minute decimals, then no fraction at all.
        push_text("$GPRMC,081836,A,3751.65123456,S,14507.3,E,,\n");
        push_text("$GPRMC,081836,A,3751,S,14507,E,,\n");
        // All fields empty.
        push_text("$GPRMC,,,,,,,\n");
        // Flag fields: the first character decides.
        push_text("$GPRMC,1,AX,1,SX,1,WX,\n");
        push_text("$GPRMC,1,XA,1,NS,1,EW,\n");
        push_text("$GPRMC,1,a,1,s,1,w,\n");
        // Stray characters and a second decimal point.
        push_text("$GPRMC,12a3:4.5.6,A,48x07.03.84,N,0z1131.0.00,E,,\n");
        // Non-ASCII bytes inside the time field.
        push_text("$GPRMC,12");
        push_char(8'hFF);
        push_char(8'h80);
        push_char(8'h00);
        push_text("34,A,1,N,1,E,,\n");
        // A dollar sign restarts the sentence.
        push_text("$GPRMC,123519,A,48$GNRMC,010203,A,1234.5678,S,01234.5678,W,,\n");
        // Text outside any sentence is ignored.
        push_text("noise,1,2\n,A\n");
        // Wrong headers.
        push_text("$GPRNC,1,A,1,N,1,E,,\n");
        push_text("$GPRMD,1,A,1,N,1,E,,\n");
        push_text("$GPGGA,1,A,1,N,1,E,,\n");
        // Early newlines: inside the header, before the seventh comma and just after it.
        push_text("$GPR\n");
        push_text("$\n");
        push_text("$GPRMC,1,A,1,N,1,E\n");
        push_text("$GPRMC,1,A,1,N,1,E,\n");
        // Length limit: the last allowed newline position, then one past it.
        push_text(padded_line("$GPRMC,1,A,4807.038,N,01131.000,E,", MAX_SENTENCE_LEN_DEF - 1));
        push_text(padded_line("$GPRMC,1,A,4807.038,N,01131.000,E,", MAX_SENTENCE_LEN_DEF));
        // Comma count saturation and punctuation in the header.
        push_text("$GPRMC,1,A,1,N,1,E,,,,,,,,,,,,,,,,,,,,\n");
        push_text("$,,,MC,1,A,1,N,1,E,,\n");
        push_marker(STIM_DRAIN);

        // Random sentences, broken sentences and line noise.
        queued_chars = 0;
        good_lines   = 0;
        iter         = 0;
        while (queued_chars < MIN_RANDOM_CHARS || good_lines < MIN_GOOD_LINES ||
               iter < RANDOM_ITERS)
        begin
            if (iter == 4)
            begin
                push_marker(STIM_HOLD_OUT);
            end
            if (iter == 0 || iter == 4)
            begin
                push_marker(STIM_CALM_TOGGLE);
            end
            if (iter == 12)
            begin
                push_marker(STIM_DRAIN);
            end
            k = $urandom_range(99);
            if (k < 75)
            begin
                push_text(make_rmc());
                good_lines++;
            end
            else if (k < 90)
            begin
                s = make_rmc();
                k = $urandom_range(1, s.len() - 2);
                case ($urandom_range(4))
                    0: s = {s.substr(0, k), "\n"};
                    1: s = {s.substr(0, k), make_rmc()};
                    2: s[$urandom_range(4, 5)] = 8'($urandom_range(8'h41, 8'h5A));
                    3: s[k] = 8'($urandom_range(1, 255));
                    default: s = padded_line(s.substr(0, s.len() - 2),
                                             $urandom_range(120, 140));
                endcase
                push_text(s);
            end
            else
            begin
                k = queued_chars;
                repeat ($urandom_range(1, 8))
                begin
                    push_char(8'($urandom_range(0, 255)));
                end
                queued_chars = k;
            end
            iter++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every character has been taken and all fixes reported.
        do
        begin
            @(negedge clk);
        end
        while (stim_q.size() != 0 || in_valid || drain_wait);
        wait_cycles = 0;
        while (pending_fixes.size() != 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (TAIL_CYCLES) @(negedge clk);
        if (pending_fixes.size() != 0)
        begin
            $error("%0d expected fixes were never reported", pending_fixes.size());
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/nrmc_pkg.sv
hdl/nrmc_deg_conv.sv
hdl/nmea_rmc_sentence_parser.sv
hdl/nrmc_checker.sv
tb/sv/nmea_rmc_sentence_parser_tb.sv
